// ----- design/mhsd_pkg.sv -----
// Shared types and constants for the science packet deframer.
// No dependencies; used by the decoder, the top level and the testbench.
package mhsd_pkg;

	localparam int CNT_W  = 11;
	localparam int LINE_W = 16;

	localparam logic [CNT_W-1:0] PKT_LAST   = 11'd1285;
	localparam logic [CNT_W-1:0] OFS_MUX    = 11'd9;
	localparam logic [CNT_W-1:0] OFS_SHELF  = 11'd12;
	localparam logic [CNT_W-1:0] OFS_STATUS = 11'd39;
	localparam logic [CNT_W-1:0] PIX_BASE   = 11'd49;
	localparam logic [CNT_W-1:0] PRT_BASE   = 11'd1225;
	localparam logic [CNT_W-1:0] PCAL_BASE  = 11'd1235;
	localparam logic [CNT_W-1:0] PCAL_END   = 11'd1241;

	localparam logic [6:0] CAL_GROUP  = 7'd90;
	localparam logic [6:0] WARM_GROUP = 7'd94;
	localparam logic [6:0] LAST_POS   = 7'd89;
	localparam logic [6:0] MAX_FRAME  = 7'd79;

	// 2^16 / 12 rounded up; exact quotient for offsets below 1176
	localparam logic [12:0] RECIP_12 = 13'd5462;

	localparam logic [2:0] KIND_PIXEL  = 3'd0;
	localparam logic [2:0] KIND_COLD   = 3'd1;
	localparam logic [2:0] KIND_WARM   = 3'd2;
	localparam logic [2:0] KIND_PRT    = 3'd3;
	localparam logic [2:0] KIND_PCAL   = 3'd4;
	localparam logic [2:0] KIND_MUX    = 3'd5;
	localparam logic [2:0] KIND_SHELF  = 3'd6;
	localparam logic [2:0] KIND_STATUS = 3'd7;

	localparam logic [1:0] WMODE_BYTE   = 2'd0;
	localparam logic [1:0] WMODE_PAIR   = 2'd1;
	localparam logic [1:0] WMODE_NIBBLE = 2'd2;

	typedef struct packed {
		logic       emit;
		logic       hold;
		logic [2:0] kind;
		logic [2:0] chan;
		logic [6:0] pixel;
		logic [2:0] slot;
		logic [1:0] wmode;
	} dec_t;

endpackage

// ----- design/mhsd_byte_if.sv -----
// Input channel: one instrument byte with its frame number and byte index.
// Plain valid/ready handshake; no package dependency.
interface mhsd_byte_if;
	logic       valid;
	logic       ready;
	logic [6:0] minor_frame;
	logic [5:0] byte_index;
	logic [7:0] byte_value;

	modport source (output valid, minor_frame, byte_index, byte_value, input ready);
	modport sink   (input valid, minor_frame, byte_index, byte_value, output ready);
endinterface

// ----- design/mhsd_word_if.sv -----
// Output channel: one decoded packet word with its tags.
// Plain valid/ready handshake; no package dependency.
interface mhsd_word_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [2:0]  chan;
	logic [6:0]  pixel;
	logic [2:0]  slot;
	logic [15:0] line;
	logic [15:0] word;

	modport source (output valid, kind, chan, pixel, slot, line, word, input ready);
	modport sink   (input valid, kind, chan, pixel, slot, line, word, output ready);
endinterface

// ----- design/mhsd_decode.sv -----
// Packet offset decoder: maps a packet byte offset to word kind, tags and role.
// Depends on mhsd_pkg.
module mhsd_decode (
	input  logic [10:0]    offset,
	input  logic [6:0]     limit,
	output mhsd_pkg::dec_t dec
);

	logic [10:0] rel;
	logic [23:0] prod;
	logic [6:0]  pos;
	logic [10:0] pos12;
	logic [10:0] rem_full;
	logic [3:0]  m;
	logic [3:0]  k;
	logic [10:0] prt_rel;
	logic        in_pix;
	logic        in_prt;

	assign rel      = offset - mhsd_pkg::PIX_BASE;
	assign prod     = 24'(rel) * 24'(mhsd_pkg::RECIP_12);
	assign pos      = prod[22:16];
	assign pos12    = (11'(pos) << 3) + (11'(pos) << 2);
	assign rem_full = rel - pos12;
	assign m        = rem_full[3:0];
	assign k        = m - 4'd2;
	assign in_pix   = (offset >= mhsd_pkg::PIX_BASE) && (offset < mhsd_pkg::PRT_BASE);
	assign in_prt   = (offset >= mhsd_pkg::PRT_BASE) && (offset < mhsd_pkg::PCAL_END);
	assign prt_rel  = offset - ((offset < mhsd_pkg::PCAL_BASE) ? mhsd_pkg::PRT_BASE
	                                                           : mhsd_pkg::PCAL_BASE);

	always_comb begin
		dec = '0;
		if (offset == mhsd_pkg::OFS_MUX) begin
			dec.emit = 1'b1;
			dec.kind = mhsd_pkg::KIND_MUX;
		end else if (offset == mhsd_pkg::OFS_SHELF) begin
			dec.emit = 1'b1;
			dec.kind = mhsd_pkg::KIND_SHELF;
		end else if (offset == mhsd_pkg::OFS_STATUS) begin
			dec.emit = 1'b1;
			dec.kind = mhsd_pkg::KIND_STATUS;
		end else if (in_pix) begin
			if ((m >= 4'd2) && ((pos >= mhsd_pkg::CAL_GROUP) || (pos < limit))) begin
				dec.hold  = ~k[0];
				dec.emit  = k[0];
				dec.chan  = k[3:1];
				dec.wmode = mhsd_pkg::WMODE_PAIR;
				if (pos < mhsd_pkg::CAL_GROUP) begin
					dec.kind  = mhsd_pkg::KIND_PIXEL;
					dec.pixel = mhsd_pkg::LAST_POS - pos;
				end else if (pos < mhsd_pkg::WARM_GROUP) begin
					dec.kind = mhsd_pkg::KIND_COLD;
					dec.slot = 3'(pos - mhsd_pkg::CAL_GROUP);
				end else begin
					dec.kind = mhsd_pkg::KIND_WARM;
					dec.slot = 3'(pos - mhsd_pkg::WARM_GROUP);
				end
			end
		end else if (in_prt) begin
			dec.hold  = ~prt_rel[0];
			dec.emit  = prt_rel[0];
			dec.kind  = (offset < mhsd_pkg::PCAL_BASE) ? mhsd_pkg::KIND_PRT
			                                           : mhsd_pkg::KIND_PCAL;
			dec.slot  = prt_rel[3:1];
			dec.wmode = mhsd_pkg::WMODE_NIBBLE;
		end
	end

endmodule

// ----- design/mhs_science_packet_deframer.sv -----
// Top level of the science packet deframer: input register, packet counters,
// offset decode and result register. Depends on mhsd_pkg, mhsd_byte_if,
// mhsd_word_if and mhsd_decode.
//
//   channel    dir  handshake     payload
//   bytes      in   valid/ready   minor_frame, byte_index, byte_value
//   words      out  valid/ready   kind, chan, pixel, slot, line, word
//   cfg        in   cfg_we        cfg_wdata = pixels_per_line
//
// One byte per cycle unless the word side stalls; each result passes through the
// input register, then the result register. Counters update as a byte leaves
// the input register. Reset clears counters, held byte and sets 90 positions.
// A stalled result holds both stages; bytes.ready drops only when both are full.
module mhs_science_packet_deframer (
	input  logic              clk,
	input  logic              arst_n,
	mhsd_byte_if.sink         bytes,
	mhsd_word_if.source       words,
	input  logic              cfg_we,
	input  logic [6:0]        cfg_wdata
);

	logic        v_s1;
	logic [6:0]  mf_s1;
	logic [5:0]  bi_s1;
	logic [7:0]  bv_s1;

	logic [10:0] cnt_q;
	logic [15:0] line_q;
	logic [7:0]  held_q;
	logic [6:0]  ppl_q;

	logic        res_vld_q;
	logic [2:0]  res_kind_q;
	logic [2:0]  res_chan_q;
	logic [6:0]  res_pixel_q;
	logic [2:0]  res_slot_q;
	logic [15:0] res_line_q;
	logic [15:0] res_word_q;

	logic        advance;
	logic        fire;
	logic [5:0]  lo;
	logic [5:0]  hi;
	logic        counted;
	logic        restart;
	logic [10:0] offset;
	logic [6:0]  limit;
	logic [15:0] word_val;
	logic [8:0]  nib_sum;
	mhsd_pkg::dec_t dec;

	assign advance     = ~res_vld_q | words.ready;
	assign bytes.ready = ~v_s1 | advance;

	always_comb begin
		lo = 6'd0;
		hi = 6'd49;
		case (mf_s1)
			7'd0:    lo = 6'd48;
			7'd26:   hi = 6'd33;
			7'd27:   lo = 6'd32;
			7'd53:   hi = 6'd17;
			7'd54:   lo = 6'd14;
			default: ;
		endcase
	end

	assign counted = (mf_s1 <= mhsd_pkg::MAX_FRAME) && (bi_s1 >= lo) && (bi_s1 <= hi);
	assign restart = ((mf_s1 == 7'd0) || (mf_s1 == 7'd27) || (mf_s1 == 7'd54))
	                 && (bi_s1 == lo);
	assign offset  = restart ? 11'd0 : cnt_q;
	assign limit   = (ppl_q > mhsd_pkg::CAL_GROUP) ? mhsd_pkg::CAL_GROUP : ppl_q;
	assign fire    = v_s1 & advance & counted;

	mhsd_decode u_decode (
		.offset (offset),
		.limit  (limit),
		.dec    (dec)
	);

	assign nib_sum = {1'b0, held_q[3:0], 4'b0000} + {1'b0, bv_s1};

	always_comb begin
		case (dec.wmode)
			mhsd_pkg::WMODE_PAIR:   word_val = {held_q, bv_s1};
			mhsd_pkg::WMODE_NIBBLE: word_val = {7'd0, nib_sum};
			default:                word_val = {8'd0, bv_s1};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (bytes.ready) begin
			v_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			mf_s1 <= bytes.minor_frame;
			bi_s1 <= bytes.byte_index;
			bv_s1 <= bytes.byte_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			line_q <= '0;
			held_q <= '0;
		end else if (fire) begin
			if (dec.hold) begin
				held_q <= bv_s1;
			end
			if (offset == mhsd_pkg::PKT_LAST) begin
				cnt_q  <= '0;
				line_q <= line_q + 16'd1;
			end else begin
				cnt_q <= offset + 11'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppl_q <= 7'd90;
		end else if (cfg_we) begin
			ppl_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (advance) begin
			res_vld_q <= fire & dec.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && dec.emit) begin
			res_kind_q  <= dec.kind;
			res_chan_q  <= dec.chan;
			res_pixel_q <= dec.pixel;
			res_slot_q  <= dec.slot;
			res_line_q  <= line_q;
			res_word_q  <= word_val;
		end
	end

	assign words.valid = res_vld_q;
	assign words.kind  = res_kind_q;
	assign words.chan  = res_chan_q;
	assign words.pixel = res_pixel_q;
	assign words.slot  = res_slot_q;
	assign words.line  = res_line_q;
	assign words.word  = res_word_q;

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= mhsd_pkg::PKT_LAST)
		else $error("packet byte counter out of range");

	a_pixel_tags: assert property (@(posedge clk) disable iff (!arst_n)
		(words.valid && (words.kind == mhsd_pkg::KIND_PIXEL))
		|-> ((words.pixel <= mhsd_pkg::LAST_POS) && (words.chan <= 3'd4)))
		else $error("pixel word with bad tags");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && res_vld_q && !words.ready) |-> !bytes.ready)
		else $error("byte taken while both stages are full");
`endif

endmodule

// ----- tb/mhsd_deframer_checker.sv -----
`timescale 1ns / 100ps
// Word checker for the science packet deframer: predicts the decoded words from
// the byte transfers and compares them with the word transfers.
// Depends on mhsd_pkg, mhsd_byte_if and mhsd_word_if.
module mhsd_deframer_checker (
	input  logic       clk,
	input  logic       arst_n,
	mhsd_byte_if       bytes,
	mhsd_word_if       words,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	output int         fails,
	output int         pending
);

	typedef struct {
		logic [2:0]  kind;
		logic [2:0]  chan;
		logic [6:0]  pixel;
		logic [2:0]  slot;
		logic [15:0] line;
		logic [15:0] word;
	} word_rec_t;

	word_rec_t                   expected_words[$];
	logic [mhsd_pkg::CNT_W-1:0]  byte_count;
	logic [mhsd_pkg::LINE_W-1:0] line_count;
	logic [7:0]                  held_byte;
	logic [6:0]                  positions;

	function automatic void queue_word(input logic [2:0] kind, input logic [2:0] chan,
			input logic [6:0] pixel, input logic [2:0] slot, input logic [15:0] word);
		word_rec_t rec;
		rec.kind  = kind;
		rec.chan  = chan;
		rec.pixel = pixel;
		rec.slot  = slot;
		rec.line  = line_count;
		rec.word  = word;
		expected_words.push_back(rec);
	endfunction

	function automatic void decode_byte(input logic [6:0] mf, input logic [5:0] bi,
			input logic [7:0] bv);
		logic [5:0] first;
		logic [5:0] last;
		int ofs;
		int pos;
		int k;
		int lim;
		first = 6'd0;
		last  = 6'd49;
		if (mf > mhsd_pkg::MAX_FRAME)
			return;
		case (mf)
			7'd0:  first = 6'd48;
			7'd26: last  = 6'd33;
			7'd27: first = 6'd32;
			7'd53: last  = 6'd17;
			7'd54: first = 6'd14;
			default: ;
		endcase
		if (bi < first || bi > last)
			return;
		if (bi == first && (mf == 7'd0 || mf == 7'd27 || mf == 7'd54))
			byte_count = '0;
		ofs = int'(byte_count);
		if (ofs == mhsd_pkg::OFS_MUX) begin
			queue_word(mhsd_pkg::KIND_MUX, 3'd0, 7'd0, 3'd0, {8'h00, bv});
		end else if (ofs == mhsd_pkg::OFS_SHELF) begin
			queue_word(mhsd_pkg::KIND_SHELF, 3'd0, 7'd0, 3'd0, {8'h00, bv});
		end else if (ofs == mhsd_pkg::OFS_STATUS) begin
			queue_word(mhsd_pkg::KIND_STATUS, 3'd0, 7'd0, 3'd0, {8'h00, bv});
		end else if (ofs >= mhsd_pkg::PIX_BASE && ofs < mhsd_pkg::PRT_BASE) begin
			pos = (ofs - mhsd_pkg::PIX_BASE) / 12;
			k   = (ofs - mhsd_pkg::PIX_BASE) % 12 - 2;
			lim = positions > mhsd_pkg::CAL_GROUP ? mhsd_pkg::CAL_GROUP : positions;
			if (k >= 0 && !(pos < mhsd_pkg::CAL_GROUP && pos >= lim)) begin
				if (k % 2 == 0)
					held_byte = bv;
				else if (pos < mhsd_pkg::CAL_GROUP)
					queue_word(mhsd_pkg::KIND_PIXEL, 3'(k / 2),
						7'(mhsd_pkg::LAST_POS - pos), 3'd0, {held_byte, bv});
				else if (pos < mhsd_pkg::WARM_GROUP)
					queue_word(mhsd_pkg::KIND_COLD, 3'(k / 2), 7'd0,
						3'(pos - mhsd_pkg::CAL_GROUP), {held_byte, bv});
				else
					queue_word(mhsd_pkg::KIND_WARM, 3'(k / 2), 7'd0,
						3'(pos - mhsd_pkg::WARM_GROUP), {held_byte, bv});
			end
		end else if (ofs >= mhsd_pkg::PRT_BASE && ofs < mhsd_pkg::PCAL_END) begin
			k = ofs < mhsd_pkg::PCAL_BASE ? ofs - mhsd_pkg::PRT_BASE
			                              : ofs - mhsd_pkg::PCAL_BASE;
			if (k % 2 == 0)
				held_byte = bv;
			else
				queue_word(ofs < mhsd_pkg::PCAL_BASE ? mhsd_pkg::KIND_PRT
				                                     : mhsd_pkg::KIND_PCAL,
					3'd0, 7'd0, 3'(k / 2),
					16'({held_byte[3:0], 4'h0}) + 16'(bv));
		end
		if (byte_count == mhsd_pkg::PKT_LAST) begin
			byte_count = '0;
			line_count = line_count + 1'b1;
		end else begin
			byte_count = byte_count + 1'b1;
		end
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			fails++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		word_rec_t want;
		if (!arst_n) begin
			byte_count = '0;
			line_count = '0;
			held_byte  = '0;
			positions  = 7'd90;
			fails      = 0;
			expected_words.delete();
		end else begin
			if (cfg_we)
				positions = cfg_wdata;
			if (words.valid && words.ready) begin
				if (expected_words.size() == 0) begin
					fails++;
					$display("%0t: word transfer, expected none, actual kind %0d word %h",
						$time, words.kind, words.word);
				end else begin
					want = expected_words.pop_front();
					check_field("kind", want.kind, words.kind);
					check_field("chan", want.chan, words.chan);
					check_field("pixel", want.pixel, words.pixel);
					check_field("slot", want.slot, words.slot);
					check_field("line", want.line, words.line);
					check_field("word", want.word, words.word);
				end
			end
			if (bytes.valid && bytes.ready)
				decode_byte(bytes.minor_frame, bytes.byte_index, bytes.byte_value);
		end
		pending = expected_words.size();
	end

endmodule

// ----- tb/tb_mhs_science_packet_deframer.sv -----
`timescale 1ns / 100ps
// Testbench top for the science packet deframer: clock, reset, byte stimulus,
// word-side stalls, configuration phases and the verdict.
// Depends on mhsd_pkg, the channel interfaces, the block and mhsd_deframer_checker.
module tb_mhs_science_packet_deframer;

	localparam int STALL_PCT   = 26;
	localparam int QUIET_LIMIT = 1000;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [6:0] cfg_wdata = 7'd90;
	logic       steady    = 1'b0;
	int         fails;
	int         pending;
	int         quiet_cycles = 0;
	int         cur_frame;
	int         cur_index;

	mhsd_byte_if bytes_if ();
	mhsd_word_if words_if ();

	mhs_science_packet_deframer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (bytes_if),
		.words     (words_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	mhsd_deframer_checker words_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (bytes_if),
		.words     (words_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fails     (fails),
		.pending   (pending)
	);

	always #6 clk = ~clk;

	initial begin
		words_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			words_if.ready <= steady || ($urandom_range(99) >= STALL_PCT);
		end
	end

	always @(posedge clk) begin
		if ((bytes_if.valid && bytes_if.ready) || (words_if.valid && words_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("mhs_science_packet_deframer regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic void frame_span(input int mf, output int first, output int last);
		first = 0;
		last  = 49;
		case (mf)
			0:  first = 48;
			26: last  = 33;
			27: first = 32;
			53: last  = 17;
			54: first = 14;
			default: ;
		endcase
	endfunction

	// call at a falling edge; returns at the falling edge after the transfer
	task automatic push_byte(input logic [6:0] mf, input logic [5:0] bi, input logic [7:0] bv);
		while (!steady && $urandom_range(99) < STALL_PCT) begin
			bytes_if.valid <= 1'b0;
			@(negedge clk);
		end
		bytes_if.valid       <= 1'b1;
		bytes_if.minor_frame <= mf;
		bytes_if.byte_index  <= bi;
		bytes_if.byte_value  <= bv;
		do @(posedge clk); while (!bytes_if.ready);
		@(negedge clk);
	endtask

	task automatic push_noise();
		int f;
		int first;
		int last;
		f = $urandom_range(79);
		frame_span(f, first, last);
		case ($urandom_range(2))
			0: push_byte(7'($urandom_range(127, 80)), 6'($urandom_range(63)), 8'($urandom));
			1: push_byte(7'(f), 6'($urandom_range(63, last + 1)), 8'($urandom));
			default: begin
				if (first > 0)
					push_byte(7'(f), 6'($urandom_range(first - 1)), 8'($urandom));
				else
					push_byte(7'(f), 6'($urandom_range(63, last + 1)), 8'($urandom));
			end
		endcase
	endtask

	task automatic start_packet(input int mf);
		int last;
		cur_frame = mf;
		frame_span(mf, cur_index, last);
	endtask

	task automatic walk(input int count, input int noise_pct, input int break_pct);
		int first;
		int last;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < noise_pct)
				push_noise();
			if ($urandom_range(99) < break_pct) begin
				if ($urandom_range(1)) begin
					cur_index += $urandom_range(5, 1);
				end else begin
					cur_frame = $urandom_range(79);
					frame_span(cur_frame, first, last);
					cur_index = $urandom_range(last, first);
				end
			end
			frame_span(cur_frame, first, last);
			if (cur_index > last) begin
				cur_frame = (cur_frame + 1) % 80;
				frame_span(cur_frame, cur_index, last);
			end
			push_byte(7'(cur_frame), 6'(cur_index), 8'($urandom));
			cur_index++;
		end
	endtask

	task automatic write_positions(input logic [6:0] value);
		bytes_if.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		bytes_if.valid       = 1'b0;
		bytes_if.minor_frame = '0;
		bytes_if.byte_index  = '0;
		bytes_if.byte_value  = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// drop: frame number out of range, then bytes outside the ranges of frames 0, 26, 27, 53, 54; then counted bytes
		push_byte(7'd127, 6'd0, 8'hFF);
		push_byte(7'd80, 6'd49, 8'h00);
		push_byte(7'd0, 6'd47, 8'hFF);
		push_byte(7'd0, 6'd63, 8'h00);
		push_byte(7'd26, 6'd34, 8'hFF);
		push_byte(7'd27, 6'd31, 8'h00);
		push_byte(7'd53, 6'd18, 8'hFF);
		push_byte(7'd54, 6'd13, 8'h00);
		for (int n = 0; n < 13; n++)
			push_byte(7'd54, 6'(14 + n), (n % 2 == 1) ? 8'hFF : 8'h00);
		push_byte(7'd27, 6'd32, 8'hA5);

		start_packet(0);
		walk(200, 8, 0);
		steady = 1'b1;
		walk(300, 8, 0);
		steady = 1'b0;
		walk(200, 8, 0);
		bytes_if.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		walk(590, 8, 0);

		write_positions(7'd1);
		start_packet(27);
		walk(160, 8, 3);

		write_positions(7'($urandom_range(14, 2)));
		start_packet(0);
		walk(200, 10, 4);

		write_positions(7'd90);
		start_packet(54);
		walk(120, 8, 4);

		bytes_if.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (8) @(negedge clk);
		if (fails == 0 && pending == 0)
			$display("mhs_science_packet_deframer regression: pass");
		else
			$display("mhs_science_packet_deframer regression: fail");
		$finish;
	end

endmodule
